@@ rtl/core/tsi_pkg.sv @@
// ----------------------------------------------------------------------------
// tsi_pkg
// Shared types and fixed field widths for the iterative Taylor sine block.
// ----------------------------------------------------------------------------
`default_nettype none

package tsi_pkg;

  localparam int X_W       = 32;  // angle field
  localparam int SINE_W    = 31;  // result field
  localparam int TERMS_W   = 4;   // term count field
  localparam int TOL_W     = 28;  // tolerance register
  localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(26844);

  // one finished result, core -> output register
  typedef struct packed {
    logic [SINE_W-1:0]  sine;
    logic [TERMS_W-1:0] terms;
    logic               nc;
  } res_t;

endpackage

`default_nettype wire

@@ rtl/core/tsi_mul.sv @@
// ----------------------------------------------------------------------------
// tsi_mul
// Shared unsigned multiplier with a registered full-width product.
// ----------------------------------------------------------------------------
`default_nettype none

module tsi_mul #(
  parameter int W = 36
) (
  input  wire logic           clk,
  input  wire logic [W-1:0]   a,
  input  wire logic [W-1:0]   b,
  output logic      [2*W-1:0] prod
);

  always_ff @(posedge clk) begin
    prod <= {{W{1'b0}}, a} * {{W{1'b0}}, b};
  end

endmodule

`default_nettype wire

@@ rtl/core/tsi_core.sv @@
// ----------------------------------------------------------------------------
// tsi_core
// Series sequencer: runs the Maclaurin steps on the shared multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module tsi_core
  import tsi_pkg::*;
#(
  parameter int FRAC_BITS = 28,
  parameter int MAX_TERMS = 12
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [TOL_W-1:0] tolerance,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [X_W-1:0]   x_value,
  output logic                  res_valid,
  input  wire logic             res_ready,
  output res_t                  res
);

  // term, numerator and quotient width: |term*x*x| stays below 256.0
  localparam int W    = FRAC_BITS + 8;
  localparam int XMW  = FRAC_BITS + 3;
  localparam int EW   = ((FRAC_BITS + 3 > X_W) ? FRAC_BITS + 3 : X_W) + 1;
  localparam int SW   = EW + 4;
  localparam int CW   = (W > TOL_W) ? W : TOL_W;
  localparam int DW   = $clog2(2 * MAX_TERMS * (2 * MAX_TERMS + 1) + 1);
  localparam int CNTW = $clog2(MAX_TERMS + 1);
  localparam int IW   = $clog2(MAX_TERMS);

  localparam logic signed [EW-1:0] XLIM     = EW'(1) << (FRAC_BITS + 2);
  localparam logic signed [SW-1:0] SLIM     = SW'(2) << FRAC_BITS;
  localparam logic signed [SW-1:0] OUT_MAX  = SW'(64'd1073741823);
  localparam logic signed [SW-1:0] SAT_HI   = (FRAC_BITS >= 29) ? OUT_MAX : SLIM;
  localparam logic signed [SW-1:0] SAT_LO   = -SAT_HI - SW'((FRAC_BITS >= 29) ? 1 : 0);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_M1   = 3'd1;
  localparam logic [2:0] S_M2   = 3'd2;
  localparam logic [2:0] S_M3   = 3'd3;
  localparam logic [2:0] S_M4   = 3'd4;
  localparam logic [2:0] S_M5   = 3'd5;
  localparam logic [2:0] S_ACC  = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  // divisor (2i)(2i+1) and its reciprocal floor(2^W / d), per step
  logic [DW-1:0] d_tbl [MAX_TERMS];
  logic [W-1:0]  r_tbl [MAX_TERMS];

  for (genvar g = 0; g < MAX_TERMS; g++) begin : g_tbl
    localparam int unsigned DV = (2 * g + 2) * (2 * g + 3);
    localparam logic [W:0]  RV = ((W + 1)'(1) << W) / DV;
    assign d_tbl[g] = DW'(DV);
    assign r_tbl[g] = RV[W-1:0];
  end

  logic [2:0]             state, state_next;
  logic [CNTW-1:0]        cnt, cnt_next;
  logic                   neg, neg_next;
  logic                   below_tol, below_tol_next;
  logic [XMW-1:0]         xm, xm_next;
  logic [W-1:0]           tm, tm_next;
  logic [W-1:0]           n, n_next;
  logic [W-1:0]           q, q_next;
  logic signed [SW-1:0]   sum, sum_next;

  logic [W-1:0]           mul_a, mul_b;
  logic [2*W-1:0]         prod;

  logic signed [EW-1:0]   xs, xsat;
  logic [EW-1:0]          xabs;
  logic [IW-1:0]          idx;
  logic [DW-1:0]          d_cur;
  logic [W-1:0]           shr_val;
  logic [W-1:0]           rem;
  logic [CNTW-1:0]        cnt_inc;
  logic                   do_sub;
  logic signed [SW-1:0]   delta;
  logic signed [SW-1:0]   sat;
  logic [5:0]             cnt_ext;

  tsi_mul #(.W(W)) u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  assign idx     = cnt[IW-1:0];
  assign d_cur   = d_tbl[idx];
  assign shr_val = prod[FRAC_BITS +: W];
  assign rem     = n - prod[W-1:0];
  assign cnt_inc = cnt + CNTW'(1);
  // step i = cnt+1; odd steps subtract for positive x
  assign do_sub  = ~cnt[0] ^ neg;
  assign delta   = SW'(tm);

  // input clamp to +/-4.0 and magnitude
  always_comb begin
    xs = EW'(signed'(x_value));
    if (xs > XLIM) begin
      xsat = XLIM;
    end else if (xs < -XLIM) begin
      xsat = -XLIM;
    end else begin
      xsat = xs;
    end
    xabs = xsat[EW-1] ? EW'(-xsat) : EW'(xsat);
  end

  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    neg_next       = neg;
    below_tol_next = below_tol;
    xm_next        = xm;
    tm_next        = tm;
    n_next         = n;
    q_next         = q;
    sum_next       = sum;
    mul_a          = tm;
    mul_b          = W'(xm);
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          neg_next       = xsat[EW-1];
          xm_next        = xabs[XMW-1:0];
          tm_next        = W'(xabs[XMW-1:0]);
          sum_next       = SW'(xsat);
          cnt_next       = '0;
          below_tol_next = 1'b0;
          state_next     = S_M1;
        end
      end
      S_M1: begin
        state_next = S_M2;
      end
      S_M2: begin
        mul_a      = shr_val;
        state_next = S_M3;
      end
      S_M3: begin
        n_next     = shr_val;
        mul_a      = shr_val;
        mul_b      = r_tbl[idx];
        state_next = S_M4;
      end
      S_M4: begin
        q_next     = prod[W +: W];
        mul_a      = prod[W +: W];
        mul_b      = W'(d_cur);
        state_next = S_M5;
      end
      S_M5: begin
        // reciprocal estimate is exact or one low
        tm_next    = q + W'(rem >= W'(d_cur));
        state_next = S_ACC;
      end
      S_ACC: begin
        sum_next       = do_sub ? sum - delta : sum + delta;
        below_tol_next = CW'(tm) < CW'(tolerance);
        cnt_next       = cnt_inc;
        if (below_tol_next || cnt_inc == CNTW'(MAX_TERMS)) begin
          state_next = S_DONE;
        end else begin
          state_next = S_M2;
        end
      end
      S_DONE: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    cnt       <= cnt_next;
    neg       <= neg_next;
    below_tol <= below_tol_next;
    xm        <= xm_next;
    tm        <= tm_next;
    n         <= n_next;
    q         <= q_next;
    sum       <= sum_next;
  end

  // result saturation
  always_comb begin
    if (sum > SAT_HI) begin
      sat = SAT_HI;
    end else if (sum < SAT_LO) begin
      sat = SAT_LO;
    end else begin
      sat = sum;
    end
    cnt_ext = 6'(cnt);
  end

  // no item is taken while reset is held
  assign in_ready  = (state == S_IDLE) & ~rst;
  assign res_valid = (state == S_DONE);
  assign res.sine  = sat[SINE_W-1:0];
  assign res.terms = (cnt_ext > 6'd15) ? 4'd15 : cnt_ext[TERMS_W-1:0];
  assign res.nc    = ~below_tol;

endmodule

`default_nettype wire

@@ rtl/core/taylor_sine_iterative_top.sv @@
// ----------------------------------------------------------------------------
// taylor_sine_iterative_top
// Maclaurin-series sine of a signed fixed-point angle, one shared multiplier.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready, x_value): one item is a signed angle
//   with FRAC_BITS fraction bits, clamped to +/-4.0 on entry.
//   Output channel (out_valid/out_ready): sine_value (clamped to +/-2.0 and
//   the 31-bit field), terms_used, not_converged.
//   cfg_we/cfg_data write the tolerance register at any edge; change it only
//   while no item is in flight.
// Timing:
//   Each series step runs through the sequencer states on the shared multiplier
//   (two products by |x|, one reciprocal product, one back-multiply for the
//   quotient fix-up, then accumulate/test), for 1..MAX_TERMS steps per item;
//   the next item is accepted only after the current one has finished.
//   in_ready is high only while the sequencer is idle.
// Reset: rst is synchronous; it idles the sequencer, empties the output
//   register and reloads tolerance with about 1e-4.
// Stall: a result waits in the output register; the core may finish its next
//   item meanwhile and then holds it until the register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module taylor_sine_iterative_top
  import tsi_pkg::*;
#(
  parameter int FRAC_BITS = 28,
  parameter int MAX_TERMS = 12
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [TOL_W-1:0]   cfg_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [X_W-1:0]     x_value,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [SINE_W-1:0]       sine_value,
  output logic [TERMS_W-1:0]      terms_used,
  output logic                    not_converged
);

  logic [TOL_W-1:0] tolerance;
  logic             res_valid;
  logic             res_ready;
  res_t             res;

  // tolerance register, Q0.FRAC_BITS
  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance <= TOL_RESET;
    end else if (cfg_we) begin
      tolerance <= cfg_data;
    end
  end

  tsi_core #(
    .FRAC_BITS (FRAC_BITS),
    .MAX_TERMS (MAX_TERMS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .tolerance (tolerance),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .x_value   (x_value),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // output register: free when empty or being drained this cycle
  assign res_ready = ~out_valid | out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      sine_value    <= res.sine;
      terms_used    <= res.terms;
      not_converged <= res.nc;
    end
  end

endmodule

`default_nettype wire
